// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the blob tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bta assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bta assertion failed");

`endif

// ===== rtl/bta_pkg.sv =====
// Shared types, codes and constants of the blob track association block.
`default_nettype none

package bta_pkg;

    localparam int VELOCITY_WINDOW_DEF = 5;
    localparam int MAX_BLOBS_DEF       = 64;

    localparam int BOX_W    = 12;
    localparam int PIX_W    = 14;
    localparam int AVG_W    = 22;
    localparam int CONF_W   = 5;
    localparam int MAXC_W   = 4;
    localparam int PCT_W    = 8;
    localparam int CHOSEN_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int MUL_W    = 23;
    localparam int DIST_W   = 2 * BOX_W;
    localparam int ACC_W    = 30;
    localparam int GATE_W   = 20;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 112;

    localparam int PCT_SCALE = 100;
    localparam int Q_SHIFT   = 8;

    typedef enum logic [S_TUSER_W-1:0] {
        KIND_START = 2'd0,
        KIND_BLOB  = 2'd1,
        KIND_EOF   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DIST = 2'd0,
        REG_MAX_DEV  = 2'd1,
        REG_MAX_CONF = 2'd2
    } reg_idx_t;

    localparam logic [BOX_W-1:0]  MAX_DIST_RST = 12'd30;
    localparam logic [PCT_W-1:0]  MAX_DEV_RST  = 8'd80;
    localparam logic [MAXC_W-1:0] MAX_CONF_RST = 4'd6;

endpackage

`default_nettype wire

// ===== rtl/bta_mul.sv =====
// Shared registered signed multiplier of the blob tracker.
`default_nettype none

module bta_mul
    import bta_pkg::*;
#(
    parameter int W = MUL_W
) (
    input  wire logic                  aclk,
    input  wire logic signed [W-1:0]   op_a,
    input  wire logic signed [W-1:0]   op_b,
    output logic signed [2*W-1:0]      prod
);

    logic signed [2*W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/bta_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bta_div
    import bta_pkg::*;
#(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  qbit;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb begin
        trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
        if (qbit) begin
            rem_next = DIVISOR_W'(trial - {1'b0, den_reg});
        end else begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quot_reg <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quot_reg <= {quot_reg[DIVIDEND_W-2:0], qbit};
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/blob_track_association.sv =====
// Top level: single-object blob tracker with frame gating and velocity averaging.
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | tuser kind, tdata blob box
//  m_      | out | m_tvalid/m_tready  | tdata track state after end of frame
//  cfg_    | in  | cfg_valid/cfg_ready| register index and write data
//
// A start item loads the track from its box and returns to idle. A candidate blob
// passes through the shared multiplier for two size gates, dx^2, dy^2 and limit^2.
// At end of frame the one-bit-per-cycle divider runs once per axis, unless
// the track is marked for deletion and the result goes straight out.
// Reset is synchronous and active low; no clearing pass is needed.
// A held result stalls only the next end of frame, in its final cycle.
`default_nettype none

module blob_track_association
    import bta_pkg::*;
#(
    parameter int VELOCITY_WINDOW = VELOCITY_WINDOW_DEF,
    parameter int MAX_BLOBS       = MAX_BLOBS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // box_x, box_y, box_width, box_height
    input  wire logic [S_TUSER_W-1:0]   s_tuser,   // kind
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // assigned, chosen_index, centroid_x, centroid_y, track_box_x, track_box_y,
    // confidence, marked_delete, avg_velocity_x, avg_velocity_y, zero pad
    output logic [M_TDATA_W-1:0]        m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W  = $clog2(MAX_BLOBS + 1);
    localparam int IDX_W  = $clog2(MAX_BLOBS);
    localparam int POS_W  = $clog2(VELOCITY_WINDOW);
    localparam int HIST_W = $clog2(VELOCITY_WINDOW + 2);
    localparam int NUM_W  = AVG_W + HIST_W + 1;
    localparam int MAG_W  = NUM_W - 1;
    localparam int PAD_W  = M_TDATA_W - (2 + CHOSEN_W + 2 * PIX_W + 2 * BOX_W
                                         + CONF_W + 2 * AVG_W);

    localparam logic signed [31:0] PIX_HI = (32'sd1 <<< (PIX_W - 1)) - 32'sd1;
    localparam logic signed [31:0] PIX_LO = -PIX_HI - 32'sd1;
    localparam logic signed [31:0] AVG_HI = (32'sd1 <<< (AVG_W - 1)) - 32'sd1;
    localparam logic signed [31:0] AVG_LO = -AVG_HI - 32'sd1;
    localparam logic signed [16:0] EDGE_HI = 17'sd4095;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_BLOB_W,
        ST_BLOB_H,
        ST_BLOB_DX,
        ST_BLOB_DY,
        ST_BLOB_LIM,
        ST_BLOB_CMP,
        ST_EOF,
        ST_SUB,
        ST_VEL,
        ST_AVG_MUL,
        ST_AVG_DIV,
        ST_AVG_WAIT,
        ST_OUT
    } state_t;

    function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [31:0] v);
        if (v > PIX_HI) return PIX_W'(PIX_HI);
        if (v < PIX_LO) return PIX_W'(PIX_LO);
        return PIX_W'(v);
    endfunction

    function automatic logic signed [AVG_W-1:0] sat_avg(input logic signed [31:0] v);
        if (v > AVG_HI) return AVG_W'(AVG_HI);
        if (v < AVG_LO) return AVG_W'(AVG_LO);
        return AVG_W'(v);
    endfunction

    function automatic logic signed [15:0] round_q8(input logic signed [AVG_W-1:0] a);
        logic [AVG_W-1:0] m;
        logic [AVG_W-1:0] r;
        m = a[AVG_W-1] ? AVG_W'(-a) : AVG_W'(a);
        r = (m + AVG_W'(128)) >> Q_SHIFT;
        return a[AVG_W-1] ? -$signed(16'(r)) : $signed(16'(r));
    endfunction

    function automatic logic [BOX_W-1:0] box_edge(input logic signed [PIX_W-1:0] c,
                                                  input logic [BOX_W-1:0] size);
        logic signed [16:0] e;
        e = 17'(c) - $signed({6'b0, size[BOX_W-1:1]});
        if (e < 17'sd0) return '0;
        if (e > EDGE_HI) return BOX_W'(EDGE_HI);
        return BOX_W'(e);
    endfunction

    state_t state_reg;

    logic [BOX_W-1:0]  max_dist_reg;
    logic [PCT_W-1:0]  max_dev_reg;
    logic [MAXC_W-1:0] max_conf_reg;

    logic [S_TUSER_W-1:0] in_kind_reg;
    logic [BOX_W-1:0] in_x_reg, in_y_reg, in_w_reg, in_h_reg;
    logic [IDX_W-1:0] in_idx_reg;

    logic [BOX_W-1:0] last_x_reg, last_y_reg, last_w_reg, last_h_reg;
    logic signed [PIX_W-1:0] last_cx_reg, last_cy_reg;
    logic signed [PIX_W-1:0] new_cx_reg, new_cy_reg;
    logic signed [PIX_W-1:0] ring_x_reg [VELOCITY_WINDOW];
    logic signed [PIX_W-1:0] ring_y_reg [VELOCITY_WINDOW];
    logic [POS_W-1:0]  pos_reg;
    logic [HIST_W-1:0] hist_reg;
    logic signed [AVG_W-1:0] avg_x_reg, avg_y_reg;
    logic signed [CONF_W-1:0] conf_reg;
    logic delete_reg;

    logic [BOX_W-1:0] best_x_reg, best_y_reg, best_w_reg, best_h_reg;
    logic [DIST_W-1:0] best_d2_reg;
    logic [CNT_W-1:0] counter_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic best_valid_reg;

    logic fail_reg;
    logic [ACC_W-1:0] acc_reg;

    logic signed [PIX_W-1:0] vx_reg, vy_reg, oldx_reg, oldy_reg;
    logic rec_reg;
    logic comp_reg;
    logic sign_reg;
    logic taken_reg;

    logic m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic                      div_start;
    logic [MAG_W-1:0]          div_dividend;
    logic [HIST_W-1:0]         div_divisor;
    logic                      div_done;
    logic [MAG_W-1:0]          div_quot;

    bta_mul #(.W(MUL_W)) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    bta_div #(.DIVIDEND_W(MAG_W), .DIVISOR_W(HIST_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Candidate geometry
    logic [BOX_W-1:0]  dw_abs, dh_abs;
    logic [GATE_W-1:0] dw100, dh100;
    logic [BOX_W:0]    cand_cx, cand_cy;
    logic signed [15:0] dx, dy;
    logic [DIST_W-1:0] limit;

    always_comb begin
        dw_abs  = (in_w_reg >= last_w_reg) ? in_w_reg - last_w_reg : last_w_reg - in_w_reg;
        dh_abs  = (in_h_reg >= last_h_reg) ? in_h_reg - last_h_reg : last_h_reg - in_h_reg;
        dw100   = GATE_W'(dw_abs) * GATE_W'(PCT_SCALE);
        dh100   = GATE_W'(dh_abs) * GATE_W'(PCT_SCALE);
        cand_cx = {1'b0, in_x_reg} + {2'b0, in_w_reg[BOX_W-1:1]};
        cand_cy = {1'b0, in_y_reg} + {2'b0, in_h_reg[BOX_W-1:1]};
        dx      = $signed({3'b0, cand_cx}) - 16'(last_cx_reg);
        dy      = $signed({3'b0, cand_cy}) - 16'(last_cy_reg);
        limit   = best_valid_reg ? best_d2_reg : prod[DIST_W-1:0];
    end

    // Averaging datapath
    logic signed [AVG_W-1:0] avg_sel;
    logic signed [PIX_W-1:0] v_sel, old_sel;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] q_s;
    logic signed [AVG_W-1:0] avg_new;

    always_comb begin
        avg_sel = comp_reg ? avg_y_reg : avg_x_reg;
        v_sel   = comp_reg ? vy_reg : vx_reg;
        old_sel = comp_reg ? oldy_reg : oldx_reg;
        if (rec_reg) begin
            num = $signed(prod[NUM_W-1:0]) + (NUM_W'(v_sel) <<< Q_SHIFT);
        end else begin
            num = (NUM_W'(v_sel) - NUM_W'(old_sel)) <<< Q_SHIFT;
        end
        div_dividend = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        div_divisor  = rec_reg ? hist_reg : HIST_W'(VELOCITY_WINDOW);
        div_start    = (state_reg == ST_AVG_DIV);
        q_s = sign_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        if (rec_reg) begin
            avg_new = sat_avg(32'(q_s));
        end else begin
            avg_new = sat_avg(32'(avg_sel) + 32'(q_s));
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_BLOB_W: begin
                mul_a = MUL_W'($signed({1'b0, last_w_reg}));
                mul_b = MUL_W'($signed({1'b0, max_dev_reg}));
            end
            ST_BLOB_H: begin
                mul_a = MUL_W'($signed({1'b0, last_h_reg}));
                mul_b = MUL_W'($signed({1'b0, max_dev_reg}));
            end
            ST_BLOB_DX: begin
                mul_a = MUL_W'(dx);
                mul_b = MUL_W'(dx);
            end
            ST_BLOB_DY: begin
                mul_a = MUL_W'(dy);
                mul_b = MUL_W'(dy);
            end
            ST_BLOB_LIM: begin
                mul_a = MUL_W'($signed({1'b0, max_dist_reg}));
                mul_b = MUL_W'($signed({1'b0, max_dist_reg}));
            end
            ST_AVG_MUL: begin
                mul_a = MUL_W'(avg_sel);
                mul_b = MUL_W'($signed({1'b0, hist_reg - 1'b1}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // End-of-frame helpers
    logic signed [CONF_W-1:0] maxc_s, conf_inc, conf_dec;
    logic signed [PIX_W-1:0]  sub_cx, sub_cy, taken_cx, taken_cy;
    logic signed [PIX_W-1:0]  vel_x, vel_y;
    logic [IDX_W+CHOSEN_W-1:0] chosen_wide;

    always_comb begin
        maxc_s   = $signed({1'b0, max_conf_reg});
        conf_inc = (conf_reg < maxc_s) ? conf_reg + 5'sd1 : maxc_s;
        conf_dec = (conf_reg > -5'sd1) ? conf_reg - 5'sd1 : conf_reg;
        sub_cx   = sat_pix(32'(last_cx_reg) + 32'(round_q8(avg_x_reg)));
        sub_cy   = sat_pix(32'(last_cy_reg) + 32'(round_q8(avg_y_reg)));
        taken_cx = $signed({1'b0, {1'b0, best_x_reg} + {2'b0, best_w_reg[BOX_W-1:1]}});
        taken_cy = $signed({1'b0, {1'b0, best_y_reg} + {2'b0, best_h_reg[BOX_W-1:1]}});
        vel_x    = sat_pix(32'(new_cx_reg) - 32'(last_cx_reg));
        vel_y    = sat_pix(32'(new_cy_reg) - 32'(last_cy_reg));
        chosen_wide = {CHOSEN_W'(0), taken_reg ? best_idx_reg : IDX_W'(0)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_dist_reg   <= MAX_DIST_RST;
            max_dev_reg    <= MAX_DEV_RST;
            max_conf_reg   <= MAX_CONF_RST;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_w_reg     <= '0;
            last_h_reg     <= '0;
            last_cx_reg    <= '0;
            last_cy_reg    <= '0;
            pos_reg        <= '0;
            hist_reg       <= '0;
            avg_x_reg      <= '0;
            avg_y_reg      <= '0;
            conf_reg       <= '0;
            delete_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            counter_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MAX_DIST: max_dist_reg <= cfg_data;
                    REG_MAX_DEV:  max_dev_reg  <= cfg_data[PCT_W-1:0];
                    REG_MAX_CONF: max_conf_reg <= cfg_data[MAXC_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_kind_reg <= s_tuser;
                        in_x_reg    <= s_tdata[11:0];
                        in_y_reg    <= s_tdata[23:12];
                        in_w_reg    <= s_tdata[35:24];
                        in_h_reg    <= s_tdata[47:36];
                        in_idx_reg  <= counter_reg[IDX_W-1:0];
                        unique case (s_tuser)
                            KIND_START: state_reg <= ST_START;
                            KIND_BLOB: begin
                                if (counter_reg < CNT_W'(MAX_BLOBS)) begin
                                    counter_reg <= counter_reg + 1'b1;
                                    state_reg   <= ST_BLOB_W;
                                end
                            end
                            KIND_EOF: state_reg <= ST_EOF;
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_START: begin
                    last_x_reg     <= in_x_reg;
                    last_y_reg     <= in_y_reg;
                    last_w_reg     <= in_w_reg;
                    last_h_reg     <= in_h_reg;
                    last_cx_reg    <= $signed({1'b0, cand_cx});
                    last_cy_reg    <= $signed({1'b0, cand_cy});
                    pos_reg        <= '0;
                    hist_reg       <= '0;
                    avg_x_reg      <= '0;
                    avg_y_reg      <= '0;
                    conf_reg       <= '0;
                    delete_reg     <= 1'b0;
                    best_valid_reg <= 1'b0;
                    counter_reg    <= '0;
                    state_reg      <= ST_IDLE;
                end
                ST_BLOB_W: state_reg <= ST_BLOB_H;
                ST_BLOB_H: begin
                    fail_reg  <= (dw100 > prod[GATE_W-1:0]);
                    state_reg <= ST_BLOB_DX;
                end
                ST_BLOB_DX: begin
                    fail_reg  <= fail_reg | (dh100 > prod[GATE_W-1:0]);
                    state_reg <= ST_BLOB_DY;
                end
                ST_BLOB_DY: begin
                    acc_reg   <= prod[ACC_W-1:0];
                    state_reg <= ST_BLOB_LIM;
                end
                ST_BLOB_LIM: begin
                    acc_reg   <= acc_reg + prod[ACC_W-1:0];
                    state_reg <= ST_BLOB_CMP;
                end
                ST_BLOB_CMP: begin
                    if (!fail_reg && (acc_reg < ACC_W'(limit))) begin
                        best_valid_reg <= 1'b1;
                        best_d2_reg    <= acc_reg[DIST_W-1:0];
                        best_idx_reg   <= in_idx_reg;
                        best_x_reg     <= in_x_reg;
                        best_y_reg     <= in_y_reg;
                        best_w_reg     <= in_w_reg;
                        best_h_reg     <= in_h_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_EOF: begin
                    taken_reg <= best_valid_reg;
                    if (best_valid_reg) begin
                        last_x_reg <= best_x_reg;
                        last_y_reg <= best_y_reg;
                        last_w_reg <= best_w_reg;
                        last_h_reg <= best_h_reg;
                        new_cx_reg <= taken_cx;
                        new_cy_reg <= taken_cy;
                        conf_reg   <= conf_inc;
                        state_reg  <= ST_VEL;
                    end else begin
                        conf_reg <= conf_dec;
                        if (conf_dec <= 5'sd0) begin
                            delete_reg <= 1'b1;
                            state_reg  <= ST_OUT;
                        end else begin
                            state_reg <= ST_SUB;
                        end
                    end
                end
                ST_SUB: begin
                    new_cx_reg <= sub_cx;
                    new_cy_reg <= sub_cy;
                    last_x_reg <= box_edge(sub_cx, last_w_reg);
                    last_y_reg <= box_edge(sub_cy, last_h_reg);
                    state_reg  <= ST_VEL;
                end
                ST_VEL: begin
                    vx_reg   <= vel_x;
                    vy_reg   <= vel_y;
                    oldx_reg <= ring_x_reg[pos_reg];
                    oldy_reg <= ring_y_reg[pos_reg];
                    ring_x_reg[pos_reg] <= vel_x;
                    ring_y_reg[pos_reg] <= vel_y;
                    last_cx_reg <= new_cx_reg;
                    last_cy_reg <= new_cy_reg;
                    rec_reg  <= (hist_reg < HIST_W'(VELOCITY_WINDOW));
                    if (hist_reg < HIST_W'(VELOCITY_WINDOW + 1)) begin
                        hist_reg <= hist_reg + 1'b1;
                    end
                    pos_reg  <= (pos_reg == POS_W'(VELOCITY_WINDOW - 1)) ? '0
                                                                         : pos_reg + 1'b1;
                    comp_reg  <= 1'b0;
                    state_reg <= ST_AVG_MUL;
                end
                ST_AVG_MUL: state_reg <= ST_AVG_DIV;
                ST_AVG_DIV: begin
                    sign_reg  <= num[NUM_W-1];
                    state_reg <= ST_AVG_WAIT;
                end
                ST_AVG_WAIT: begin
                    if (div_done) begin
                        if (comp_reg) begin
                            avg_y_reg <= avg_new;
                            state_reg <= ST_OUT;
                        end else begin
                            avg_x_reg <= avg_new;
                            comp_reg  <= 1'b1;
                            state_reg <= ST_AVG_MUL;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {PAD_W'(0), avg_y_reg, avg_x_reg, delete_reg,
                                         conf_reg, last_y_reg, last_x_reg, last_cy_reg,
                                         last_cx_reg, chosen_wide[CHOSEN_W-1:0], taken_reg};
                        best_valid_reg <= 1'b0;
                        counter_reg    <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bta_checker.sv =====
// Port-level checker of the blob tracker and its bind.
`default_nettype none
`include "assert_macros.svh"

module bta_checker
    import bta_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TUSER_W-1:0]  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata
);

    `BTA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BTA_ASSERT_NXT(a_no_quick_result, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid))
    `BTA_ASSERT_IMP(a_conf_range, aclk, aresetn, m_tvalid, !m_tdata[63] || m_tdata[63:59] == 5'h1F)
    `BTA_ASSERT_IMP(a_miss_index, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[6:1] == 6'd0)

endmodule

bind blob_track_association bta_checker u_bta_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
